// ===== rtl/bse_pkg.sv =====
// Shared constants and types for the bubble sort engine.
// No dependencies.
package bse_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

endpackage

// ===== rtl/bubble_sort_engine.sv =====
// Bubble sort engine top level: batch store in a synchronous RAM, bubble
// passes by read-compare-write, sorted readout. Depends on bse_pkg.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_value, i_last_in
//   result    out        o_valid / i_ready  o_sorted_value, o_last_out, o_overflow
//
// Loading accepts one transaction per cycle while o_ready is high. After the
// last transaction bubble passes run by read-compare-write (one synchronous
// RAM read port, one write port) until one makes no swap. A stalled result
// holds. Readout reads each result, then registers it once the output is
// free. Reset clears the count, the overflow flag and all handshakes; the
// RAM is not cleared. While the last result stalls, the next batch may load.
module bubble_sort_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bse_pkg::t_data i_value,
    input  logic           i_last_in,
    output logic           o_valid,
    input  logic           i_ready,
    output bse_pkg::t_data o_sorted_value,
    output logic           o_last_out,
    output logic           o_overflow
);
    import bse_pkg::*;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_PASS0   = 3'd1;
    localparam logic [2:0] S_PASS    = 3'd2;
    localparam logic [2:0] S_PEND    = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_LD = 3'd5;

    t_data mem [DEPTH];
    t_data r_rdata;

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    logic       r_ovf, n_ovf;
    logic       r_swapped, n_swapped;
    t_addr      r_k, n_k;
    t_addr      r_e, n_e;
    t_data      r_carry, n_carry;
    logic       r_o_valid, n_o_valid;
    t_data      r_o_value, n_o_value;
    logic       r_o_last, n_o_last;
    logic       r_o_ovf, n_o_ovf;

    logic  wr_en;
    t_addr wr_addr;
    t_data wr_data;
    t_addr rd_addr;
    t_cnt  last_idx;
    logic  k_last;
    logic  e_last;
    logic  in_xact;

    assign last_idx = r_count - 1'b1;
    assign k_last   = ({{(CNT_W-ADDR_W){1'b0}}, r_k} == last_idx);
    assign e_last   = ({{(CNT_W-ADDR_W){1'b0}}, r_e} == last_idx);
    assign o_ready  = (r_state == S_LOAD);
    assign in_xact  = i_valid && o_ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_swapped = r_swapped;
        n_k       = r_k;
        n_e       = r_e;
        n_carry   = r_carry;
        n_o_valid = r_o_valid && !i_ready;
        n_o_value = r_o_value;
        n_o_last  = r_o_last;
        n_o_ovf   = r_o_ovf;
        wr_en     = 1'b0;
        wr_addr   = r_count[ADDR_W-1:0];
        wr_data   = i_value;
        rd_addr   = r_e;
        case (r_state)
            S_LOAD: begin
                if (in_xact) begin
                    if (r_count < CNT_W'(DEPTH)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state   = S_PASS0;
                        n_swapped = 1'b0;
                    end
                end
            end
            S_PASS0: begin
                rd_addr = '0;
                n_k     = '0;
                n_state = S_PASS;
            end
            S_PASS: begin
                rd_addr = r_k + 1'b1;
                if (r_k == '0) begin
                    n_carry = r_rdata;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_k - 1'b1;
                    if (r_carry > r_rdata) begin
                        wr_data   = r_rdata;
                        n_swapped = 1'b1;
                    end else begin
                        wr_data = r_carry;
                        n_carry = r_rdata;
                    end
                end
                if (k_last) begin
                    n_state = S_PEND;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_PEND: begin
                wr_en   = 1'b1;
                wr_addr = last_idx[ADDR_W-1:0];
                wr_data = r_carry;
                if (r_swapped) begin
                    n_swapped = 1'b0;
                    n_state   = S_PASS0;
                end else begin
                    n_e     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_value = r_rdata;
                    n_o_last  = e_last;
                    n_o_ovf   = r_ovf;
                    if (e_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_swapped <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_swapped <= n_swapped;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_e       <= n_e;
        r_carry   <= n_carry;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_valid        = r_o_valid;
    assign o_sorted_value = r_o_value;
    assign o_last_out     = r_o_last;
    assign o_overflow     = r_o_ovf;

endmodule
